// ----- src/bdpa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdpa_pkg
// Shared types and codes of the binary delta patch apply unit.
// ----------------------------------------------------------------------------
package bdpa_pkg;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_SPANS,
    PH_PAYLOAD,
    PH_DRAIN
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRC_RD,
    ST_EMIT,
    ST_CHECK,
    ST_SUM_CHECK,
    ST_STATUS
  } state_t;

  localparam logic [2:0] STAT_OK           = 3'd0;
  localparam logic [2:0] STAT_TRUNCATED    = 3'd1;
  localparam logic [2:0] STAT_BAD_COUNT    = 3'd2;
  localparam logic [2:0] STAT_BAD_SPAN     = 3'd3;
  localparam logic [2:0] STAT_SUM_MISMATCH = 3'd4;
  localparam logic [2:0] STAT_LEN_MISMATCH = 3'd5;

  localparam logic OP_SOURCE = 1'b0;
  localparam logic OP_PATCH  = 1'b1;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [2:0] FIRST_WORD_LAST  = 3'd3;
  localparam logic [2:0] SECOND_WORD_LAST = 3'd7;

  localparam int OUT_TDATA_W  = 48;
  localparam int BYTE_COUNT_W = 31;

  typedef struct packed {
    logic accept;
    logic src_rd;
    logic emit;
    logic check;
    logic sum_check;
    logic status;
  } bdpa_cmd_t;

  typedef struct packed {
    logic is_patch;
    logic need_check;
    logic need_emit;
    logic need_src;
    logic last_held;
    logic span_done;
    logic out_free;
  } bdpa_sts_t;

endpackage
`default_nettype wire

// ----- src/bdpa_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdpa_ctrl
// Sequencer that steps each accepted word through source read, span check,
// data output and status output.
// ----------------------------------------------------------------------------
module bdpa_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_last,
  output logic                    in_ready,
  input  wire bdpa_pkg::bdpa_sts_t sts,
  output bdpa_pkg::bdpa_cmd_t     cmd
);
  import bdpa_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && sts.is_patch) begin
          if (sts.need_check) begin
            state_next = ST_CHECK;
          end else if (sts.need_src) begin
            state_next = ST_SRC_RD;
          end else if (sts.need_emit) begin
            state_next = ST_EMIT;
          end else if (in_last) begin
            state_next = ST_STATUS;
          end
        end
      end
      ST_SRC_RD: state_next = ST_EMIT;
      ST_EMIT: begin
        if (sts.out_free) begin
          state_next = sts.last_held ? ST_STATUS : ST_IDLE;
        end
      end
      ST_CHECK: begin
        if (sts.span_done) begin
          state_next = ST_SUM_CHECK;
        end else begin
          state_next = sts.last_held ? ST_STATUS : ST_IDLE;
        end
      end
      ST_SUM_CHECK: state_next = sts.last_held ? ST_STATUS : ST_IDLE;
      ST_STATUS: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = (state == ST_IDLE) && !rst;
    cmd.accept    = (state == ST_IDLE) && !rst && in_valid;
    cmd.src_rd    = (state == ST_SRC_RD);
    cmd.emit      = (state == ST_EMIT) && sts.out_free;
    cmd.check     = (state == ST_CHECK);
    cmd.sum_check = (state == ST_SUM_CHECK);
    cmd.status    = (state == ST_STATUS) && sts.out_free;
  end

endmodule
`default_nettype wire

// ----- src/bdpa_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdpa_datapath
// Source memory, span table, header parsing, span checks and output register.
// ----------------------------------------------------------------------------
module bdpa_datapath #(
  parameter int SRC_DEPTH = 65536,
  parameter int MAX_SPANS = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire bdpa_pkg::bdpa_cmd_t  cmd,
  input  wire logic                 in_opcode,
  input  wire logic [7:0]           in_data,
  input  wire logic                 in_last,
  output bdpa_pkg::bdpa_sts_t       sts,
  input  wire logic                 out_ready,
  output logic                      out_valid,
  output logic                      out_kind,
  output logic [7:0]                out_byte,
  output logic [2:0]                out_status,
  output logic [bdpa_pkg::BYTE_COUNT_W-1:0] out_count,
  output logic                      out_end
);
  import bdpa_pkg::*;

  localparam int AW = $clog2(SRC_DEPTH);
  localparam int SW = $clog2(MAX_SPANS + 1);
  localparam int TW = (MAX_SPANS > 1) ? $clog2(MAX_SPANS) : 1;
  localparam logic [AW:0] SRC_DEPTH_L = (AW + 1)'(SRC_DEPTH);
  localparam logic [31:0] MAX_SPANS_L = 32'(MAX_SPANS);

  logic [7:0]        src_mem [SRC_DEPTH];
  logic [7:0]        src_q;
  logic [2*AW:0]     tab_mem [MAX_SPANS];
  logic [2*AW:0]     tab_q;

  logic [AW:0]       load_ptr;
  logic [AW:0]       src_len;
  logic [31:0]       hdr;
  phase_t            phase;
  logic [2:0]        cnt;
  logic [31:0]       declared;
  logic [SW-1:0]     span_count;
  logic [31:0]       covered;
  logic [SW-1:0]     cur_span;
  logic [AW-1:0]     offset;
  logic [31:0]       payload_count;
  logic [2:0]        err;
  logic [31:0]       start_hold;
  logic [7:0]        byte_q;
  logic              xor_q;
  logic              last_q;

  logic [31:0]       hdr_new;
  logic [31:0]       limit;
  logic              emit_ok;
  logic              need_src_w;
  logic              span_bad;
  logic [32:0]       src_len_x;
  logic [AW-1:0]     tab_start;
  logic [AW:0]       tab_len;
  logic [AW-1:0]     src_addr;
  logic [AW:0]       offset_inc;
  logic [AW:0]       load_ptr_new;
  logic [2:0]        stat_code;
  logic [BYTE_COUNT_W-1:0] emitted;

  always_comb begin
    hdr_new    = {in_data, hdr[31:8]};
    limit      = declared[31] ? 32'd0 : declared;
    emit_ok    = (phase == PH_PAYLOAD) && (err == STAT_OK) && (payload_count < limit);
    need_src_w = emit_ok && (span_count != '0) && (cur_span < span_count);
    src_len_x  = 33'(src_len);
    tab_start  = tab_q[AW-1:0];
    tab_len    = tab_q[2*AW:AW];
    src_addr   = tab_start + offset;
    offset_inc = {1'b0, offset} + 1'b1;
    load_ptr_new = (load_ptr < SRC_DEPTH_L) ? load_ptr + 1'b1 : load_ptr;
    span_bad   = start_hold[31] || hdr[31] || (hdr == 32'd0) ||
                 ({1'b0, hdr} > src_len_x) || declared[31] ||
                 (({1'b0, covered} + {1'b0, hdr}) > {1'b0, declared}) ||
                 (({1'b0, start_hold} + {1'b0, hdr}) > src_len_x);

    if (phase == PH_HEADER) begin
      stat_code = STAT_TRUNCATED;
    end else if ((phase == PH_SPANS) || (err == STAT_BAD_COUNT)) begin
      stat_code = STAT_BAD_COUNT;
    end else if (declared[31] || (payload_count != declared)) begin
      stat_code = STAT_LEN_MISMATCH;
    end else begin
      stat_code = err;
    end
    if ((phase == PH_PAYLOAD) && (err == STAT_OK) && !declared[31]) begin
      emitted = (payload_count < declared) ? payload_count[BYTE_COUNT_W-1:0]
                                           : declared[BYTE_COUNT_W-1:0];
    end else begin
      emitted = '0;
    end

    sts.is_patch   = (in_opcode == OP_PATCH);
    sts.need_check = (in_opcode == OP_PATCH) && (phase == PH_SPANS) &&
                     (cnt == SECOND_WORD_LAST);
    sts.need_emit  = (in_opcode == OP_PATCH) && emit_ok;
    sts.need_src   = (in_opcode == OP_PATCH) && need_src_w;
    sts.last_held  = last_q;
    sts.span_done  = ({1'b0, cur_span} + 1'b1) >= {1'b0, span_count};
    sts.out_free   = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && (in_opcode == OP_SOURCE) && (load_ptr < SRC_DEPTH_L)) begin
      src_mem[load_ptr[AW-1:0]] <= in_data;
    end
    if (cmd.src_rd) begin
      src_q <= src_mem[src_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.check && (err == STAT_OK) && !span_bad) begin
      tab_mem[cur_span[TW-1:0]] <= {hdr[AW:0], start_hold[AW-1:0]};
    end
    tab_q <= tab_mem[cur_span[TW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      last_q <= in_last;
      if (emit_ok) begin
        byte_q <= in_data;
        xor_q  <= need_src_w;
      end
    end
    if (cmd.emit) begin
      out_kind   <= KIND_DATA;
      out_byte   <= byte_q ^ (xor_q ? src_q : 8'd0);
      out_status <= STAT_OK;
      out_count  <= '0;
      out_end    <= 1'b0;
    end else if (cmd.status) begin
      out_kind   <= KIND_STATUS;
      out_byte   <= 8'd0;
      out_status <= stat_code;
      out_count  <= emitted;
      out_end    <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_ptr      <= '0;
      src_len       <= '0;
      hdr           <= '0;
      phase         <= PH_HEADER;
      cnt           <= '0;
      declared      <= '0;
      span_count    <= '0;
      covered       <= '0;
      cur_span      <= '0;
      offset        <= '0;
      payload_count <= '0;
      err           <= STAT_OK;
      start_hold    <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cmd.emit || cmd.status) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (cmd.accept && (in_opcode == OP_SOURCE)) begin
        if (in_last) begin
          src_len  <= load_ptr_new;
          load_ptr <= '0;
        end else begin
          load_ptr <= load_ptr_new;
        end
      end else if (cmd.accept) begin
        hdr <= hdr_new;
        case (phase)
          PH_HEADER: begin
            cnt <= cnt + 1'b1;
            if (cnt == FIRST_WORD_LAST) begin
              declared <= hdr_new;
            end
            if (cnt == SECOND_WORD_LAST) begin
              covered  <= '0;
              cur_span <= '0;
              if (hdr_new[31] || (hdr_new > MAX_SPANS_L)) begin
                err   <= STAT_BAD_COUNT;
                phase <= PH_DRAIN;
              end else begin
                span_count <= hdr_new[SW-1:0];
                phase      <= (hdr_new == 32'd0) ? PH_PAYLOAD : PH_SPANS;
              end
            end
          end
          PH_SPANS: begin
            cnt <= cnt + 1'b1;
            if (cnt == FIRST_WORD_LAST) begin
              start_hold <= hdr_new;
            end
          end
          PH_PAYLOAD: begin
            if (payload_count != 32'hFFFF_FFFF) begin
              payload_count <= payload_count + 1'b1;
            end
          end
          default: ;
        endcase
      end

      if (cmd.src_rd) begin
        if (offset_inc >= tab_len) begin
          cur_span <= cur_span + 1'b1;
          offset   <= '0;
        end else begin
          offset <= offset_inc[AW-1:0];
        end
      end

      if (cmd.check) begin
        if (err == STAT_OK) begin
          if (span_bad) begin
            err <= STAT_BAD_SPAN;
          end else begin
            covered <= covered + hdr;
          end
        end
        cur_span <= cur_span + 1'b1;
      end

      if (cmd.sum_check) begin
        if ((err == STAT_OK) && (covered != declared)) begin
          err <= STAT_SUM_MISMATCH;
        end
        cur_span <= '0;
        offset   <= '0;
        phase    <= PH_PAYLOAD;
      end

      if (cmd.status) begin
        hdr           <= '0;
        phase         <= PH_HEADER;
        cnt           <= '0;
        declared      <= '0;
        span_count    <= '0;
        covered       <= '0;
        cur_span      <= '0;
        offset        <= '0;
        payload_count <= '0;
        err           <= STAT_OK;
        start_hold    <= '0;
      end
    end
  end

endmodule
`default_nettype wire

// ----- src/binary_delta_patch_apply_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// binary_delta_patch_apply_unit
// Applies a copy-and-XOR binary patch to a stored source image.
//
// The input stream carries source words (tuser low) and patch words (tuser
// high); tlast closes the source image or the patch. The output stream
// carries reconstructed data words (tuser low) and, after the final patch
// word, one status word (tuser high, tlast high) with the status code and
// the number of data words emitted.
// A source word and a header word are taken at once, as is a span word.
// The closing word of a span goes through the span check, and the closing
// word of the span table through the check and the sum check. A payload
// word that is passed through literally goes straight to the output; one
// that reads the source passes a span table read, then the dependent
// source memory read. Output lands in a register, and the next input word
// is taken while it waits. When the receiver stalls, the unit holds until
// the output register is free. Reset empties the output register and
// returns to the header phase with the source length at zero.
// ----------------------------------------------------------------------------
module binary_delta_patch_apply_unit #(
  parameter int SRC_DEPTH = 65536,
  parameter int MAX_SPANS = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // data_byte
  input  wire logic        s_axis_tuser,  // opcode
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [bdpa_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // out_byte, status, byte_count
  output logic             m_axis_tuser,  // kind
  output logic             m_axis_tlast
);
  import bdpa_pkg::*;

  bdpa_cmd_t cmd;
  bdpa_sts_t sts;
  logic [7:0]              out_byte;
  logic [2:0]              out_status;
  logic [BYTE_COUNT_W-1:0] out_count;

  bdpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_last  (s_axis_tlast),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bdpa_datapath #(
    .SRC_DEPTH (SRC_DEPTH),
    .MAX_SPANS (MAX_SPANS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .in_opcode  (s_axis_tuser),
    .in_data    (s_axis_tdata),
    .in_last    (s_axis_tlast),
    .sts        (sts),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_kind   (m_axis_tuser),
    .out_byte   (out_byte),
    .out_status (out_status),
    .out_count  (out_count),
    .out_end    (m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, out_count, out_status, out_byte};

`ifndef ASSERT_OFF
  a_data_word_clean: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == KIND_DATA) |->
      !m_axis_tlast && (m_axis_tdata[47:8] == 40'd0))
    else $error("data word carries status fields");

  a_status_word_clean: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == KIND_STATUS) |->
      m_axis_tlast && (m_axis_tdata[7:0] == 8'd0))
    else $error("status word malformed");

  a_status_code_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[10:8] != 3'd6) && (m_axis_tdata[10:8] != 3'd7))
    else $error("status code out of range");

  a_last_patch_blocks: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tlast && (s_axis_tuser == OP_PATCH)
      |=> !s_axis_tready)
    else $error("input taken before status word issued");
`endif

endmodule
`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the binary delta patch apply unit.
//
// Source images and patches are streamed in with random idle bursts on both
// sides. A behavioral predictor follows every accepted input word and queues
// the data and status words it produces. Each output word is checked against
// the oldest queued word. Patches are mostly well formed with random
// content, and the rest are truncated or corrupted.
// ----------------------------------------------------------------------------
module tb;
  import bdpa_pkg::*;

  localparam int SRC_N = 65536;
  localparam int SPAN_N = 1024;

  typedef struct packed {
    logic        op;
    logic [7:0]  data;
    logic        last;
    logic        chk;
    logic [2:0]  exp_st;
  } in_word_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  ob;
    logic [2:0]  st;
    logic [30:0] cnt;
    logic        eor;
  } out_word_t;

  typedef struct packed {
    logic        op;
    logic [31:0] val;
    logic [2:0]  nb;
    logic        last;
    logic        chk;
    logic [2:0]  exp_st;
  } dir_row_t;

  // Directed rows: nb bytes of val, lowest byte first; the status code is
  // typed in for rows that close a patch in an obvious way.
  localparam int DIR_N = 15;
  localparam dir_row_t DIR_TAB [DIR_N] = '{
    '{OP_SOURCE, 32'hFFFF_FFFF, 3'd4, 1'b0, 1'b0, STAT_OK},
    '{OP_SOURCE, 32'hFFFF_FFFF, 3'd4, 1'b0, 1'b0, STAT_OK},
    '{OP_SOURCE, 32'hFFFF_FFFF, 3'd4, 1'b0, 1'b0, STAT_OK},
    '{OP_SOURCE, 32'hFFFF_FFFF, 3'd4, 1'b1, 1'b0, STAT_OK},
    '{OP_PATCH,  32'h0000_0000, 3'd1, 1'b1, 1'b1, STAT_TRUNCATED},
    '{OP_PATCH,  32'h0000_0002, 3'd4, 1'b0, 1'b0, STAT_OK},
    '{OP_PATCH,  32'h0000_0000, 3'd4, 1'b0, 1'b0, STAT_OK},
    '{OP_PATCH,  32'h0000_FF00, 3'd2, 1'b1, 1'b1, STAT_OK},
    '{OP_PATCH,  32'h0000_0000, 3'd4, 1'b0, 1'b0, STAT_OK},
    '{OP_PATCH,  32'h0000_0455, 3'd4, 1'b1, 1'b1, STAT_BAD_COUNT},
    '{OP_PATCH,  32'h0000_0004, 3'd4, 1'b0, 1'b0, STAT_OK},
    '{OP_PATCH,  32'h0000_0001, 3'd4, 1'b0, 1'b0, STAT_OK},
    '{OP_PATCH,  32'h0000_000C, 3'd4, 1'b0, 1'b0, STAT_OK},
    '{OP_PATCH,  32'h0000_0004, 3'd4, 1'b0, 1'b0, STAT_OK},
    '{OP_PATCH,  32'h5AA5_A5A5, 3'd4, 1'b1, 1'b1, STAT_OK}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic m_axis_tlast;

  binary_delta_patch_apply_unit DUT (.*);

  always #6 clk = ~clk;

  // Predictor state.
  logic [7:0]  src_mem [SRC_N];
  logic [31:0] src_len, load_ptr;
  logic [31:0] sp_start [SPAN_N];
  logic [31:0] sp_len [SPAN_N];
  logic [31:0] shreg, decl_len, n_spans, covered, cur_span, cur_off, pay_cnt, start_hold;
  logic [31:0] hdr_cnt;
  phase_t      phase;
  logic [2:0]  err;

  out_word_t   expected_words [$];
  in_word_t    stim [$];
  int          errors = 0;
  bit          quiet = 1'b0;
  int          loaded_len = 0;

  function automatic void patch_clear();
    shreg = 0; phase = PH_HEADER; hdr_cnt = 0; decl_len = 0; n_spans = 0;
    covered = 0; cur_span = 0; cur_off = 0; pay_cnt = 0; err = STAT_OK;
    start_hold = 0;
  endfunction

  function automatic out_word_t mk(logic k, logic [7:0] b, logic [2:0] s, logic [30:0] c);
    out_word_t w;
    w.kind = k; w.ob = b; w.st = s; w.cnt = c; w.eor = k;
    return w;
  endfunction

  function automatic void predict_word(in_word_t w);
    longint s, l, d;
    logic [31:0] lim, idx;
    logic [7:0] v;
    logic [2:0] code;
    logic [31:0] emitted;
    if (w.op == OP_SOURCE) begin
      if (load_ptr < SRC_N) begin
        src_mem[load_ptr] = w.data;
        load_ptr++;
      end
      if (w.last) begin
        src_len = load_ptr;
        load_ptr = 0;
      end
      return;
    end
    shreg = {w.data, shreg[31:8]};
    d = longint'($signed(decl_len));
    case (phase)
      PH_HEADER: begin
        hdr_cnt++;
        if (hdr_cnt == 4) decl_len = shreg;
        if (hdr_cnt == 8) begin
          hdr_cnt = 0; covered = 0; cur_span = 0;
          if (shreg[31] || shreg > SPAN_N) begin
            err = STAT_BAD_COUNT; phase = PH_DRAIN;
          end else begin
            n_spans = shreg;
            phase = (n_spans == 0) ? PH_PAYLOAD : PH_SPANS;
          end
        end
      end
      PH_SPANS: begin
        hdr_cnt++;
        if (hdr_cnt == 4) start_hold = shreg;
        if (hdr_cnt == 8) begin
          hdr_cnt = 0;
          s = longint'($signed(start_hold));
          l = longint'($signed(shreg));
          if (err == STAT_OK) begin
            if (s < 0 || l <= 0 || l > longint'(src_len) ||
                longint'(covered) + l > d || s + l > longint'(src_len)) begin
              err = STAT_BAD_SPAN;
            end else begin
              sp_start[cur_span] = start_hold;
              sp_len[cur_span] = shreg;
              covered += shreg;
            end
          end
          cur_span++;
          if (cur_span >= n_spans) begin
            if (err == STAT_OK && covered != decl_len) err = STAT_SUM_MISMATCH;
            cur_span = 0; cur_off = 0; phase = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        lim = (d < 0) ? 0 : decl_len;
        if (err == STAT_OK && pay_cnt < lim) begin
          v = 0;
          if (n_spans != 0 && cur_span < n_spans) begin
            idx = sp_start[cur_span] + cur_off;
            if (idx < SRC_N) v = src_mem[idx];
            cur_off++;
            if (cur_off >= sp_len[cur_span]) begin
              cur_span++; cur_off = 0;
            end
          end
          expected_words.push_back(mk(KIND_DATA, w.data ^ v, STAT_OK, '0));
        end
        if (pay_cnt != 32'hFFFF_FFFF) pay_cnt++;
      end
      default: ;
    endcase
    if (w.last) begin
      emitted = 0;
      if (phase == PH_HEADER) code = STAT_TRUNCATED;
      else if (phase == PH_SPANS || err == STAT_BAD_COUNT) code = STAT_BAD_COUNT;
      else if (d < 0 || pay_cnt != decl_len) code = STAT_LEN_MISMATCH;
      else code = err;
      if (w.chk) code = w.exp_st;
      if (phase == PH_PAYLOAD && err == STAT_OK && d >= 0)
        emitted = (pay_cnt < decl_len) ? pay_cnt : decl_len;
      expected_words.push_back(mk(KIND_STATUS, 8'h00, code, emitted[30:0]));
      patch_clear();
    end
  endfunction

  // Stimulus builders.
  function automatic void push(logic op, logic [7:0] b, logic lst);
    in_word_t w;
    w.op = op; w.data = b; w.last = lst; w.chk = 1'b0; w.exp_st = STAT_OK;
    stim.push_back(w);
  endfunction

  function automatic void push32(logic [31:0] v);
    for (int i = 0; i < 4; i++) push(OP_PATCH, v[8*i +: 8], 1'b0);
  endfunction

  function automatic void add_source(int n, bit ones);
    for (int i = 0; i < n; i++)
      push(OP_SOURCE, ones ? 8'hFF : 8'($urandom), i == n - 1);
    loaded_len = n;
  endfunction

  // Well-formed patch over the current source, with optional corruption.
  function automatic void add_patch(int flaw);
    int nsp, len, rem, st, sl, npay;
    int starts [$];
    int lens [$];
    nsp = (flaw == 9) ? 0 : $urandom_range(0, 4);
    len = 0;
    for (int i = 0; i < nsp; i++) begin
      sl = $urandom_range(1, (loaded_len < 6) ? loaded_len : 6);
      st = $urandom_range(0, loaded_len - sl);
      starts.push_back(st); lens.push_back(sl); len += sl;
    end
    if (nsp == 0) len = $urandom_range(0, 8);
    if (flaw == 1 && nsp > 0) lens[0] = loaded_len + 1;
    if (flaw == 2 && nsp > 0) starts[nsp-1] = -1;
    push32((flaw == 3) ? len + 1 : len);
    push32((flaw == 4) ? 32'h8000_0000 | $urandom : nsp);
    for (int i = 0; i < nsp; i++) begin
      push32(starts[i]);
      push32(lens[i]);
    end
    npay = len + ((flaw == 5) ? 1 : (flaw == 6 && len > 0) ? -1 : 0);
    if (flaw == 7) begin
      push(OP_PATCH, 8'($urandom), 1'b1);
      return;
    end
    if (npay == 0) begin
      // Header or table only; close on the last byte already pushed.
      stim[$].last = 1'b1;
      return;
    end
    for (int i = 0; i < npay; i++) push(OP_PATCH, 8'($urandom), i == npay - 1);
  endfunction

  // Sender.
  int sent = 0;
  bit pause_req = 1'b0;
  in_word_t cur_w;

  initial begin
    patch_clear();
    src_len = 0; load_ptr = 0;
    foreach (src_mem[i]) src_mem[i] = 8'h00;
    for (int r = 0; r < DIR_N; r++) begin
      for (int i = 0; i < int'(DIR_TAB[r].nb); i++) begin
        push(DIR_TAB[r].op, DIR_TAB[r].val[8*i +: 8],
             DIR_TAB[r].last && (i == int'(DIR_TAB[r].nb) - 1));
      end
      if (DIR_TAB[r].chk) begin
        stim[$].chk = 1'b1;
        stim[$].exp_st = DIR_TAB[r].exp_st;
      end
    end
    loaded_len = 16;
    add_source(32, 1'b0);
  end

  task automatic drive_all();
    while (stim.size() > 0) begin
      cur_w = stim.pop_front();
      s_axis_tvalid <= 1'b1;
      s_axis_tdata <= cur_w.data;
      s_axis_tuser <= cur_w.op;
      s_axis_tlast <= cur_w.last;
      @(posedge clk);
      while (!s_axis_tready) @(posedge clk);
      predict_word(cur_w);
      sent++;
      if (!quiet && $urandom_range(0, 9) == 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    drive_all();
    while (sent < 1100) begin
      if ($urandom_range(0, 4) == 0) add_source($urandom_range(8, 64), 1'b0);
      if ($urandom_range(0, 3) == 0) add_patch($urandom_range(1, 9));
      else add_patch(0);
      if (sent > 900) quiet = 1'b1;
      drive_all();
      if (sent > 500 && !pause_req) begin
        pause_req = 1'b1;
        s_axis_tvalid <= 1'b0;
        while (expected_words.size() > 0) @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b0;
    while (expected_words.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

  // Receiver with random stalls.
  int stall = 0;
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (stall > 0) begin
      stall <= stall - 1;
      m_axis_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 11) == 0) begin
      stall <= $urandom_range(0, 17);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Output checker.
  always @(posedge clk) begin
    out_word_t got, exp_w;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.kind = m_axis_tuser;
      got.ob = m_axis_tdata[7:0];
      got.st = m_axis_tdata[10:8];
      got.cnt = m_axis_tdata[41:11];
      got.eor = m_axis_tlast;
      if (expected_words.size() == 0) begin
        $display("%0t unexpected word: expected none, actual %h", $time, got);
        errors++;
      end else begin
        exp_w = expected_words.pop_front();
        if (got != exp_w) begin
          $display("%0t mismatch: expected kind %0d byte %h status %0d count %0d last %0d,",
                   $time, exp_w.kind, exp_w.ob, exp_w.st, exp_w.cnt, exp_w.eor);
          $display("%0t   actual kind %0d byte %h status %0d count %0d last %0d",
                   $time, got.kind, got.ob, got.st, got.cnt, got.eor);
          errors++;
        end
      end
    end
  end

  initial begin
    #50ms;
    $display("tb: FAIL");
    $finish;
  end
endmodule
